// ----- rtl/acl_pkg.sv -----
// ----------------------------------------------------------------------------
// acl_pkg: shared definitions for the aged lookup cache directory
// Sizes, request codes and the structure passed between the directory and
// its replacement selector.
// ----------------------------------------------------------------------------
package acl_pkg;

   // Directory geometry.
   localparam int ENTRIES       = 10;
   localparam int KEY_WIDTH     = 32;
   localparam int AGE_WIDTH     = 16;
   localparam int IDX_WIDTH     = $clog2(ENTRIES);

   // Fixed field widths of the channels.
   localparam int URL_KEY_WIDTH = 32;
   localparam int SLOT_WIDTH    = 4;

   // Request codes carried in the mode field.
   localparam logic MODE_LOOKUP = 1'b0;
   localparam logic MODE_INSERT = 1'b1;

   typedef logic [IDX_WIDTH-1:0] idx_type;
   typedef logic [AGE_WIDTH-1:0] age_type;
   typedef logic [KEY_WIDTH-1:0] key_type;

   // Replacement choice for an insert.
   typedef struct packed {
      idx_type idx;      // entry to be written
      logic    evicted;  // the chosen entry currently holds a valid key
   } victim_type;

endpackage

// ----- rtl/acl_req_if.sv -----
// ----------------------------------------------------------------------------
// acl_req_if: request channel of the aged lookup cache directory
// Valid/ready channel carrying the request mode and the object key.
// ----------------------------------------------------------------------------
interface acl_req_if
   import acl_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic                     mode;
   logic [URL_KEY_WIDTH-1:0] url_key;

   modport source (output valid, output mode, output url_key, input ready);
   modport sink   (input valid, input mode, input url_key, output ready);
endinterface

// ----- rtl/acl_rsp_if.sv -----
// ----------------------------------------------------------------------------
// acl_rsp_if: response channel of the aged lookup cache directory
// Valid/ready channel carrying the hit flag, the entry index and the
// eviction flag.
// ----------------------------------------------------------------------------
interface acl_rsp_if
   import acl_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic [SLOT_WIDTH-1:0] slot;
   logic                  evicted;

   modport source (output valid, output hit, output slot, output evicted, input ready);
   modport sink   (input valid, input hit, input slot, input evicted, output ready);
endinterface

// ----- rtl/acl_victim_sel.sv -----
// ----------------------------------------------------------------------------
// acl_victim_sel: replacement target selection
// Picks the lowest invalid entry, or when the directory is full, the
// lowest-index entry holding the largest age, through a comparison tree.
// ----------------------------------------------------------------------------
module acl_victim_sel
   import acl_pkg::*;
(
   input  logic [ENTRIES-1:0] entry_valid,
   input  age_type            entry_age [ENTRIES],
   output victim_type         victim
);

   localparam int LEAVES = 1 << IDX_WIDTH;

   age_type    node_age [2*LEAVES];
   idx_type    node_idx [2*LEAVES];
   logic       node_ok  [2*LEAVES];
   idx_type    free_idx;
   logic       take_right;

   // Heap-ordered tree: leaves sit at LEAVES+i, node n has children 2n, 2n+1.
   // The right child wins only on a strictly larger age, so ties go low.
   always_comb begin
      for (int i = 0; i < LEAVES; i++) begin
         if (i < ENTRIES) begin
            node_age[LEAVES+i] = entry_age[i];
            node_ok[LEAVES+i]  = 1'b1;
         end else begin
            node_age[LEAVES+i] = '0;
            node_ok[LEAVES+i]  = 1'b0;
         end
         node_idx[LEAVES+i] = IDX_WIDTH'(i);
      end
      node_age[0] = '0;
      node_idx[0] = '0;
      node_ok[0]  = 1'b0;
      for (int n = LEAVES - 1; n >= 1; n--) begin
         take_right = node_ok[2*n+1] &&
                      (!node_ok[2*n] || (node_age[2*n+1] > node_age[2*n]));
         node_age[n] = take_right ? node_age[2*n+1] : node_age[2*n];
         node_idx[n] = take_right ? node_idx[2*n+1] : node_idx[2*n];
         node_ok[n]  = node_ok[2*n] || node_ok[2*n+1];
      end
   end

   // Lowest-index free entry.
   always_comb begin
      free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!entry_valid[i]) begin
            free_idx = IDX_WIDTH'(i);
         end
      end
   end

   assign victim.evicted = &entry_valid;
   assign victim.idx     = victim.evicted ? node_idx[1] : free_idx;

endmodule

// ----- rtl/aged_lookup_cache_replacement.sv -----
// ----------------------------------------------------------------------------
// aged_lookup_cache_replacement: aged lookup cache directory
// Fully associative directory of keys with per-entry age counters. Lookups
// report hits and refresh ages; inserts fill a free entry or replace the
// oldest one.
// ----------------------------------------------------------------------------
//
//  Channel    Role     Transfer payload
//  ---------  -------  ----------------------------------------------
//  req_chan   sink     mode (0 lookup, 1 insert), url_key (32 bits)
//  rsp_chan   source   hit, slot (4 bits), evicted
//
// A request transfer is captured in an input register. When the response
// register is free or being taken, the directory compares, selects and
// updates its state in one step and writes the response register, so one
// request is taken every cycle while the response channel does not stall.
// The response register and the input register form a two-deep pipe: a
// stalled response holds the request in the input register, and the request
// channel keeps accepting whenever the input register is free or moving on.
// Synchronous reset invalidates every entry and sets every age to one; keys
// are left unreset since they are compared only while their entry is valid.
// ----------------------------------------------------------------------------
module aged_lookup_cache_replacement
   import acl_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   acl_req_if.sink   req_chan,
   acl_rsp_if.source rsp_chan
);

   localparam age_type AGE_MAX = '1;
   localparam age_type AGE_ONE = AGE_WIDTH'(1);

   // Input register.
   logic    item_valid_ff, item_valid_in;
   logic    item_mode_ff;
   key_type item_key_ff;

   // Response register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  hit_ff, hit_in;
   logic [SLOT_WIDTH-1:0] slot_ff, slot_in;
   logic                  evicted_ff, evicted_in;

   // Directory state.
   logic [ENTRIES-1:0] entry_valid_ff, entry_valid_in;
   key_type            entry_key_ff [ENTRIES];
   age_type            entry_age_ff [ENTRIES];
   age_type            entry_age_in [ENTRIES];

   logic               advance;
   logic               req_take;
   logic [ENTRIES-1:0] match;
   logic               hit_any;
   idx_type            hit_idx;
   idx_type            write_idx;
   logic               key_write;
   victim_type         victim;
   age_type            base_age;

   // The held item moves on when the response register is empty or its
   // content is being taken in this cycle.
   assign advance  = item_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !item_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   assign item_valid_in = req_take || (item_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_mode_ff <= req_chan.mode;
         item_key_ff  <= req_chan.url_key[KEY_WIDTH-1:0];
      end
   end

   // Parallel key compare; the lowest matching entry wins.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = entry_valid_ff[i] && (entry_key_ff[i] == item_key_ff);
      end
      hit_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_idx = IDX_WIDTH'(i);
         end
      end
   end

   assign hit_any = |match;

   acl_victim_sel u_victim_sel (
      .entry_valid (entry_valid_ff),
      .entry_age   (entry_age_ff),
      .victim      (victim)
   );

   assign write_idx = victim.idx;
   assign key_write = advance && (item_mode_ff == MODE_INSERT);

   // Next directory state. A lookup refreshes the hit entry and then ages
   // every entry with saturation; an insert only touches its target.
   always_comb begin
      entry_valid_in = entry_valid_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         entry_age_in[i] = entry_age_ff[i];
         base_age = entry_age_ff[i];
         if (advance) begin
            if (item_mode_ff == MODE_LOOKUP) begin
               if (hit_any && (hit_idx == IDX_WIDTH'(i))) begin
                  base_age = AGE_ONE;
               end
               entry_age_in[i] = (base_age == AGE_MAX) ? base_age : base_age + AGE_ONE;
            end else if (write_idx == IDX_WIDTH'(i)) begin
               entry_age_in[i]   = AGE_ONE;
               entry_valid_in[i] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            entry_age_ff[i] <= AGE_ONE;
         end
      end else begin
         entry_valid_ff <= entry_valid_in;
         for (int i = 0; i < ENTRIES; i++) begin
            entry_age_ff[i] <= entry_age_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (key_write) begin
         entry_key_ff[write_idx] <= item_key_ff;
      end
   end

   // Response formation.
   always_comb begin
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);
      hit_in       = hit_ff;
      slot_in      = slot_ff;
      evicted_in   = evicted_ff;
      if (advance) begin
         if (item_mode_ff == MODE_LOOKUP) begin
            hit_in     = hit_any;
            slot_in    = hit_any ? SLOT_WIDTH'(hit_idx) : '0;
            evicted_in = 1'b0;
         end else begin
            hit_in     = 1'b0;
            slot_in    = SLOT_WIDTH'(write_idx);
            evicted_in = victim.evicted;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff     <= hit_in;
      slot_ff    <= slot_in;
      evicted_ff <= evicted_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.hit     = hit_ff;
   assign rsp_chan.slot    = slot_ff;
   assign rsp_chan.evicted = evicted_ff;

   // A response only appears after an item has been processed.
   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance))
      else $error("response became valid without a processed item");

   // A processed item always leaves a response behind.
   a_item_to_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed item produced no response");

   // Hits and evictions never occur together in one response.
   a_hit_excl_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(hit_ff && evicted_ff))
      else $error("response reports both a hit and an eviction");

   // After an insert the directory is no longer empty, since the target entry is valid.
   a_insert_fills: assert property (@(posedge clock) disable iff (reset)
      key_write |=> entry_valid_ff != '0)
      else $error("insert left the directory empty");

   // An eviction can only be reported when the directory was full.
   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      (advance && (item_mode_ff == MODE_INSERT) && victim.evicted) |->
      (&entry_valid_ff))
      else $error("eviction reported with a free entry present");

endmodule
